// ===== rtl/htf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htf_pkg
// Types, constants and lookup functions shared by the HTML-to-text filter.
// ----------------------------------------------------------------------------
package htf_pkg;

    localparam int unsigned HELD_DEPTH = 5;
    localparam int unsigned NUM_ENT    = 6;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_count;
    typedef logic [NUM_ENT-1:0] t_ent_mask;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_ENTITY  = 2'd1,
        MODE_TAGHEAD = 2'd2,
        MODE_TAGBODY = 2'd3
    } t_mode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } t_ctrl_state;

    // Controller to datapath
    typedef struct packed {
        logic   step;   // commit one input beat to the scan state
        logic   load;   // load the output register
        logic   first;  // load the first byte of the current beat's list
        logic   last;   // loaded byte is the final one of its input beat
        t_count idx;    // position in the emit list
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_count total_now;   // results of the beat on the input
        t_count total_held;  // results of the beat being emitted
    } t_status;

    localparam t_byte CH_LT   = 8'h3C;
    localparam t_byte CH_GT   = 8'h3E;
    localparam t_byte CH_AMP  = 8'h26;
    localparam t_byte CH_LF   = 8'h0A;

    localparam t_ent_mask ENT_ALL = '1;

    function automatic t_byte fold(input t_byte c);
        t_byte r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // Character k of entity e, zero past its end
    function automatic t_byte ent_char(input t_count e, input t_count k);
        logic [47:0] s;
        logic [47:0] sh;
        case (e)
            3'd0:    s = "&nbsp;";
            3'd1:    s = {"&amp;", 8'h00};
            3'd2:    s = {"&lt;", 16'h0000};
            3'd3:    s = {"&gt;", 16'h0000};
            3'd4:    s = "&quot;";
            3'd5:    s = "&apos;";
            default: s = '0;
        endcase
        sh = s << {k, 3'b000};
        return sh[47:40];
    endfunction

    function automatic t_count ent_len(input t_count e);
        t_count r;
        case (e)
            3'd0:    r = 3'd6;
            3'd1:    r = 3'd5;
            3'd2:    r = 3'd4;
            3'd3:    r = 3'd4;
            3'd4:    r = 3'd6;
            3'd5:    r = 3'd6;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic t_byte ent_repl(input t_count e);
        t_byte r;
        case (e)
            3'd0:    r = 8'h20;
            3'd1:    r = 8'h26;
            3'd2:    r = 8'h3C;
            3'd3:    r = 8'h3E;
            3'd4:    r = 8'h22;
            3'd5:    r = 8'h27;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Character k of "br>", zero past its end
    function automatic t_byte br_char(input t_count k);
        logic [23:0] s;
        logic [23:0] sh;
        s  = "br>";
        sh = s << {k, 3'b000};
        return sh[23:16];
    endfunction

endpackage

// ===== rtl/htf_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htf_in_if
// Input stream channel: one HTML text byte per beat.
// ----------------------------------------------------------------------------
interface htf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       text_end;

    modport source (output valid, output in_byte, output text_end, input ready);
    modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

// ===== rtl/htf_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htf_out_if
// Output stream channel: one plain-text byte per beat.
// ----------------------------------------------------------------------------
interface htf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== rtl/htf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htf_datapath
// Scan state, held entity bytes, emit list and output payload register.
// ----------------------------------------------------------------------------
module htf_datapath
    import htf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_byte   i_in_byte,
    input  logic    i_text_end,
    input  t_cmd    i_cmd,
    output t_status o_status,
    output t_byte   o_out_byte,
    output logic    o_run_last
);

    t_mode     r_mode, n_mode;
    t_count    r_match_count, n_match_count;
    t_ent_mask r_alive, n_alive;
    t_byte     r_held [HELD_DEPTH];
    t_count    r_rep_n, n_rep_n;
    logic      r_tail_v, n_tail_v;
    t_byte     r_tail, n_tail;
    t_byte     r_out_byte, n_out_byte;
    logic      r_run_last;

    t_byte     fch;
    t_count    k;
    logic      held_we;
    t_count    held_waddr;
    logic      do_plain;
    logic      ent_open;
    logic      done_v;
    t_count    done_e;
    t_ent_mask next_mask;

    // One scan step on the input byte
    always_comb begin
        fch           = fold(i_in_byte);
        k             = r_match_count;
        n_mode        = r_mode;
        n_match_count = r_match_count;
        n_alive       = r_alive;
        held_we       = 1'b0;
        held_waddr    = k;
        n_rep_n       = 3'd0;
        n_tail_v      = 1'b0;
        n_tail        = i_in_byte;
        do_plain      = 1'b0;
        ent_open      = 1'b0;
        done_v        = 1'b0;
        done_e        = 3'd0;
        next_mask     = '0;

        for (int e = 0; e < NUM_ENT; e++) begin
            if (r_alive[e] && ent_len(3'(e)) > k && fch == ent_char(3'(e), k)) begin
                if (ent_len(3'(e)) == 3'(k + 3'd1)) begin
                    done_v = 1'b1;
                    done_e = 3'(e);
                end else begin
                    next_mask[e] = 1'b1;
                end
            end
        end

        case (r_mode)
            MODE_ENTITY: begin
                if (done_v) begin
                    n_tail_v      = 1'b1;
                    n_tail        = ent_repl(done_e);
                    n_mode        = MODE_PLAIN;
                    n_match_count = 3'd0;
                    n_alive       = '0;
                end else if (next_mask != '0 && k < 3'(HELD_DEPTH)) begin
                    held_we       = 1'b1;
                    n_match_count = k + 3'd1;
                    n_alive       = next_mask;
                end else begin
                    // release held bytes, then rescan the failing byte
                    n_rep_n       = (k > 3'(HELD_DEPTH)) ? 3'(HELD_DEPTH) : k;
                    n_mode        = MODE_PLAIN;
                    n_match_count = 3'd0;
                    n_alive       = '0;
                    do_plain      = 1'b1;
                end
            end
            MODE_TAGHEAD: begin
                if (k < 3'd3 && fch == br_char(k)) begin
                    if (k == 3'd2) begin
                        n_tail_v      = 1'b1;
                        n_tail        = CH_LF;
                        n_mode        = MODE_PLAIN;
                        n_match_count = 3'd0;
                        n_alive       = '0;
                    end else begin
                        n_match_count = k + 3'd1;
                    end
                end else if (i_in_byte == CH_GT) begin
                    n_mode        = MODE_PLAIN;
                    n_match_count = 3'd0;
                    n_alive       = '0;
                end else begin
                    n_mode        = MODE_TAGBODY;
                    n_match_count = 3'd0;
                end
            end
            MODE_TAGBODY: begin
                if (i_in_byte == CH_GT) begin
                    n_mode        = MODE_PLAIN;
                    n_match_count = 3'd0;
                    n_alive       = '0;
                end
            end
            default: begin
                do_plain = 1'b1;
            end
        endcase

        if (do_plain) begin
            if (i_in_byte == CH_LT) begin
                n_mode        = MODE_TAGHEAD;
                n_match_count = 3'd0;
                n_alive       = '0;
            end else if (i_in_byte == CH_AMP) begin
                n_mode        = MODE_ENTITY;
                n_match_count = 3'd1;
                n_alive       = ENT_ALL;
                held_we       = 1'b1;
                held_waddr    = 3'd0;
                ent_open      = 1'b1;
            end else begin
                n_tail_v = 1'b1;
                n_tail   = i_in_byte;
            end
        end

        // End of text: flush a pending entity, drop an open tag
        if (i_text_end) begin
            if (n_mode == MODE_ENTITY) begin
                if (ent_open) begin
                    n_tail_v = 1'b1;
                    n_tail   = CH_AMP;
                end else begin
                    n_rep_n = n_match_count;
                end
            end
            n_mode        = MODE_PLAIN;
            n_match_count = 3'd0;
            n_alive       = '0;
        end
    end

    // Emit list: held[0..rep_n-1], then the tail byte; held[0] is always '&'
    always_comb begin
        if (i_cmd.first) begin
            n_out_byte = (n_rep_n != 3'd0) ? CH_AMP : n_tail;
        end else if (i_cmd.idx < r_rep_n) begin
            n_out_byte = r_held[i_cmd.idx];
        end else begin
            n_out_byte = r_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_PLAIN;
            r_match_count <= 3'd0;
            r_alive       <= '0;
        end else if (i_cmd.step) begin
            r_mode        <= n_mode;
            r_match_count <= n_match_count;
            r_alive       <= n_alive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_rep_n  <= n_rep_n;
            r_tail_v <= n_tail_v;
            r_tail   <= n_tail;
            if (held_we) begin
                r_held[held_waddr] <= i_in_byte;
            end
        end
        if (i_cmd.load) begin
            r_out_byte <= n_out_byte;
            r_run_last <= i_cmd.last;
        end
    end

    assign o_status.total_now  = n_rep_n + {2'b00, n_tail_v};
    assign o_status.total_held = r_rep_n + {2'b00, r_tail_v};
    assign o_out_byte          = r_out_byte;
    assign o_run_last          = r_run_last;

endmodule

// ===== rtl/htf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htf_ctrl
// Handshake controller: accepts beats, walks the emit list, owns out valid.
// ----------------------------------------------------------------------------
module htf_ctrl
    import htf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_ctrl_state r_state, n_state;
    t_count      r_idx, n_idx;
    logic        r_out_valid, n_out_valid;
    logic        slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    // Outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = slot_free;
                o_cmd.step  = i_in_valid && slot_free;
                o_cmd.load  = o_cmd.step && (i_status.total_now != 3'd0);
                o_cmd.first = 1'b1;
                o_cmd.last  = (i_status.total_now == 3'd1);
                o_cmd.idx   = 3'd0;
            end
            ST_EMIT: begin
                o_cmd.load  = slot_free;
                o_cmd.first = 1'b0;
                o_cmd.last  = (r_idx == 3'(i_status.total_held - 3'd1));
                o_cmd.idx   = r_idx;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.step && i_status.total_now > 3'd1) begin
                    n_state = ST_EMIT;
                    n_idx   = 3'd1;
                end
            end
            ST_EMIT: begin
                if (o_cmd.load) begin
                    if (o_cmd.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/html_to_text_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_to_text_filter_unit
// Streaming HTML tag stripper and character entity decoder.
// ----------------------------------------------------------------------------
// Feed one HTML byte per input beat on i_in; plain text comes out one byte
// per beat on o_out, with run_last marking the final byte that an input beat
// produced (beats that produce nothing, such as tag bytes, give no output).
// A "<br>" tag (any case) turns into a newline, all other tags are dropped
// through the closing '>', and &nbsp; &amp; &lt; &gt; &quot; &apos; (any
// case) are decoded. Bytes of an entity that stops matching are released
// in their original case. Set text_end on the last byte of a text to flush
// a pending entity and discard an open tag. An input beat that yields zero
// or one output byte is taken without holding the input off, so ordinary
// text streams at one byte per clock while the output keeps up; a beat that
// yields more bytes (a failed entity or an end-of-text flush, up to six)
// holds the input off after it is taken while the controller walks the
// held-byte buffer through the single output register. While an output byte
// waits unclaimed the input is held off; a new input beat is taken in the
// cycle that the waiting byte is picked up.
// ----------------------------------------------------------------------------
module html_to_text_filter_unit
    import htf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    htf_in_if.sink        i_in,
    htf_out_if.source     o_out
);

    t_cmd    cmd;
    t_status status;

    // Handshake sequencing: accept a beat, then drain its emit list
    htf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Scan state, held entity bytes and output payload
    htf_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_byte  (i_in.in_byte),
        .i_text_end (i_in.text_end),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_byte (o_out.out_byte),
        .o_run_last (o_out.run_last)
    );

endmodule
